>>> rtl/core/json_string_unescape_core_assert.svh
// Assertion macros shared by the unescaper modules.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef JSON_STRING_UNESCAPE_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_CORE_ASSERT_SVH

// cond must never hold outside reset
`define JSU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define JSU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
// No dependencies; used by the front, queue, back and top modules.
package jsu_pkg;

    // decode mode of the front classifier
    typedef enum logic [1:0] {
        MODE_WAIT,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX
    } t_mode;

    // work entry kinds handed from front to back
    typedef enum logic [1:0] {
        OP_DATA,   // one plain byte in value[7:0]
        OP_DONE,   // closing quote
        OP_BAD,    // first byte was not a quote
        OP_CODE    // \u code point in value, 1 to 3 UTF-8 bytes
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] value;
    } t_cmd;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;

    localparam logic [15:0] CP_LIM1 = 16'h0080;
    localparam logic [15:0] CP_LIM2 = 16'h0800;
    localparam logic [7:0]  LEAD2   = 8'hC0;
    localparam logic [7:0]  LEAD3   = 8'hE0;
    localparam logic [7:0]  CONT    = 8'h80;
    localparam logic [5:0]  CONT_MASK = 6'h3F;

endpackage

>>> rtl/core/jsu_front.sv
// Front classifier: accepts raw bytes, tracks string/escape/hex state,
// pushes one work entry per byte that yields results. Depends on jsu_pkg.
module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_in_byte,
    output logic             o_push,
    output jsu_pkg::t_cmd    o_cmd
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_hex_seen, n_hex_seen;
    logic [15:0]    r_cp, n_cp;
    logic           r_stopped, n_stopped;

    logic           hex_ok;
    logic [3:0]     hex_val;

    // hex digit decode, no prefix or sign handling
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_val = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte >= 8'h61 && i_in_byte <= 8'h66) begin
            hex_val = 4'(i_in_byte - 8'h57);
        end else if (i_in_byte >= 8'h41 && i_in_byte <= 8'h46) begin
            hex_val = 4'(i_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= jsu_pkg::MODE_WAIT;
            r_hex_seen <= 2'd0;
            r_cp       <= 16'd0;
            r_stopped  <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_hex_seen <= n_hex_seen;
            r_cp       <= n_cp;
            r_stopped  <= n_stopped;
        end
    end

    // next state and work entry
    always_comb begin
        n_mode     = r_mode;
        n_hex_seen = r_hex_seen;
        n_cp       = r_cp;
        n_stopped  = r_stopped;
        o_push     = 1'b0;
        o_cmd.op    = jsu_pkg::OP_DATA;
        o_cmd.value = {8'd0, i_in_byte};
        if (i_accept) begin
            unique case (r_mode)
                jsu_pkg::MODE_WAIT: begin
                    if (i_in_byte == jsu_pkg::CH_QUOTE) begin
                        n_mode = jsu_pkg::MODE_BODY;
                    end else begin
                        o_push   = 1'b1;
                        o_cmd.op = jsu_pkg::OP_BAD;
                    end
                end
                jsu_pkg::MODE_BODY: begin
                    if (i_in_byte == jsu_pkg::CH_QUOTE) begin
                        o_push   = 1'b1;
                        o_cmd.op = jsu_pkg::OP_DONE;
                        n_mode   = jsu_pkg::MODE_WAIT;
                    end else if (i_in_byte == jsu_pkg::CH_BSLASH) begin
                        n_mode = jsu_pkg::MODE_ESC;
                    end else begin
                        o_push = 1'b1;
                    end
                end
                jsu_pkg::MODE_ESC: begin
                    n_mode = jsu_pkg::MODE_BODY;
                    o_push = 1'b1;
                    priority case (i_in_byte)
                        jsu_pkg::CH_N: o_cmd.value = {8'd0, jsu_pkg::BYTE_LF};
                        jsu_pkg::CH_T: o_cmd.value = {8'd0, jsu_pkg::BYTE_TAB};
                        jsu_pkg::CH_R: o_cmd.value = {8'd0, jsu_pkg::BYTE_CR};
                        jsu_pkg::CH_B: o_cmd.value = {8'd0, jsu_pkg::BYTE_BS};
                        jsu_pkg::CH_F: o_cmd.value = {8'd0, jsu_pkg::BYTE_FF};
                        jsu_pkg::CH_U: begin
                            o_push     = 1'b0;
                            n_mode     = jsu_pkg::MODE_HEX;
                            n_hex_seen = 2'd0;
                            n_cp       = 16'd0;
                            n_stopped  = 1'b0;
                        end
                        default: o_push = 1'b1;  // escaped byte passes as itself
                    endcase
                end
                jsu_pkg::MODE_HEX: begin
                    // first non-hex byte freezes the value
                    if (!r_stopped && hex_ok) begin
                        n_cp = {r_cp[11:0], hex_val};
                    end else begin
                        n_stopped = 1'b1;
                    end
                    if (r_hex_seen == 2'd3) begin
                        o_push      = 1'b1;
                        o_cmd.op    = jsu_pkg::OP_CODE;
                        o_cmd.value = n_cp;
                        n_mode      = jsu_pkg::MODE_BODY;
                        n_hex_seen  = 2'd0;
                    end else begin
                        n_hex_seen = r_hex_seen + 2'd1;
                    end
                end
                default: n_mode = jsu_pkg::MODE_WAIT;
            endcase
        end
    end

endmodule

>>> rtl/core/jsu_queue.sv
// Small register queue of work entries between front and back.
// Depends on jsu_pkg and the assertion macro header.
`include "json_string_unescape_core_assert.svh"
module jsu_queue #(
    parameter int Depth = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output jsu_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    jsu_pkg::t_cmd r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CntW'(Depth));

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    `JSU_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `JSU_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

>>> rtl/core/jsu_back.sv
// Back end: expands queued work entries into result items, one per cycle unless
// stalled, into a registered output stage. Depends on jsu_pkg and the assertion macros.
`include "json_string_unescape_core_assert.svh"
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [7:0]    o_data_byte,
    output logic          o_byte_valid,
    output logic          o_string_done,
    output logic          o_not_a_string,
    output logic          o_last
);

    logic [1:0] r_sub, n_sub;
    logic       r_ovalid;
    logic [7:0] r_data;
    logic       r_bvalid, r_done, r_bad, r_olast;

    logic       adv, emit, fin;
    logic [1:0] nbytes;
    logic [7:0] e_data;
    logic       e_bvalid, e_done, e_bad;
    logic [15:0] cp;

    assign cp = i_head.value;

    // output slot frees when empty or taken
    assign adv  = !r_ovalid || !i_stall;
    assign emit = adv && !i_empty;

    // UTF-8 length of the code point
    always_comb begin
        if (cp < jsu_pkg::CP_LIM1) begin
            nbytes = 2'd1;
        end else if (cp < jsu_pkg::CP_LIM2) begin
            nbytes = 2'd2;
        end else begin
            nbytes = 2'd3;
        end
    end

    // result for the current entry and sub-byte
    always_comb begin
        e_data   = 8'd0;
        e_bvalid = 1'b0;
        e_done   = 1'b0;
        e_bad    = 1'b0;
        fin      = 1'b1;
        unique case (i_head.op)
            jsu_pkg::OP_DATA: begin
                e_data   = cp[7:0];
                e_bvalid = 1'b1;
            end
            jsu_pkg::OP_DONE: e_done = 1'b1;
            jsu_pkg::OP_BAD:  e_bad  = 1'b1;
            jsu_pkg::OP_CODE: begin
                e_bvalid = 1'b1;
                fin      = (r_sub == nbytes - 2'd1);
                if (nbytes == 2'd1) begin
                    e_data = cp[7:0];
                end else if (nbytes == 2'd2) begin
                    e_data = (r_sub == 2'd0) ? (jsu_pkg::LEAD2 | {3'd0, cp[10:6]})
                                             : (jsu_pkg::CONT | {2'd0, cp[5:0]});
                end else begin
                    priority case (r_sub)
                        2'd0:    e_data = jsu_pkg::LEAD3 | {4'd0, cp[15:12]};
                        2'd1:    e_data = jsu_pkg::CONT | {2'd0, cp[11:6]};
                        default: e_data = jsu_pkg::CONT | {2'd0, cp[5:0] & jsu_pkg::CONT_MASK};
                    endcase
                end
            end
            default: e_bad = 1'b1;
        endcase
    end

    assign o_pop = emit && fin;
    assign n_sub = emit ? (fin ? 2'd0 : r_sub + 2'd1) : r_sub;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub    <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_sub <= n_sub;
            if (adv) begin
                r_ovalid <= emit;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data   <= e_data;
            r_bvalid <= e_bvalid;
            r_done   <= e_done;
            r_bad    <= e_bad;
            r_olast  <= fin;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_data_byte    = r_data;
    assign o_byte_valid   = r_bvalid;
    assign o_string_done  = r_done;
    assign o_not_a_string = r_bad;
    assign o_last         = r_olast;

    `JSU_ASSERT_NEXT(a_pop_marks_last, i_clk, i_rst_n, o_pop, r_ovalid && r_olast,
                     "entry retired without a last result")
    `JSU_ASSERT_IMP(a_sub_in_code, i_clk, i_rst_n, r_sub != 2'd0,
                    !i_empty && i_head.op == jsu_pkg::OP_CODE,
                    "partial expansion outside a code point entry")

endmodule

>>> rtl/core/json_string_unescape_core.sv
// Top level of the JSON string unescaper: front classifier, work queue, back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+---------------------------------------------
//   input   | i_valid | o_stall | i_in_byte
//   output  | o_valid | i_stall | o_data_byte o_byte_valid o_string_done
//           |         |         | o_not_a_string o_last
//
// One input item is accepted per cycle while the work queue has room.
// The back end gives one result item per cycle while the output is not stalled;
// a \u escape gives 1 to 3 result items, set by the UTF-8 length of its code point.
// Each result is registered in the queue and then in the output register.
// Reset is synchronous and active low; it clears decode state, queue and output valid.
// Output stall holds the output register; input stall rises when the queue is full.
module json_string_unescape_core #(
    parameter int QueueDepth = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_string_done,
    output logic       o_not_a_string,
    output logic       o_last
);

    logic          accept, push, pop, q_empty, q_full;
    jsu_pkg::t_cmd push_cmd, head_cmd;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    jsu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    jsu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_cmd),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_data_byte    (o_data_byte),
        .o_byte_valid   (o_byte_valid),
        .o_string_done  (o_string_done),
        .o_not_a_string (o_not_a_string),
        .o_last         (o_last)
    );

endmodule
